// ----- hw/rtl/segment_intersection_test_defines.svh -----
// ----------------------------------------------------------------------------
// segment_intersection_test_defines
// Assertion macros shared by the segment intersection RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg
// Widths, types and constants of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int MAG_W       = PROD_W;
  localparam int NUM_W       = MAG_W + COORD_WIDTH;
  localparam int IN_FIELDS   = 8;
  localparam int IN_DATA_W   = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int LIMIT_W     = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [LIMIT_W-1:0]            limit_t;

  localparam limit_t LIMIT_RESET = limit_t'(1);

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  // divider lane state: partial remainder and numerator/quotient shifter
  typedef struct packed {
    logic                   hit;
    logic                   neg_x;
    logic                   neg_y;
    coord_t                 x0;
    coord_t                 y0;
    logic [MAG_W-1:0]       den;
    logic [MAG_W-1:0]       rem_x;
    logic [COORD_WIDTH-1:0] lo_x;
    logic [MAG_W-1:0]       rem_y;
    logic [COORD_WIDTH-1:0] lo_y;
  } div_t;

  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } res_t;

  typedef struct packed {
    logic skid_full;
    logic out_busy;
  } out_stat_t;

endpackage

// ----- hw/rtl/sit_front.sv -----
// ----------------------------------------------------------------------------
// sit_front
// Five-stage front end: differences, products, cross sums, sign fix, hit
// test and divider numerators.
// ----------------------------------------------------------------------------
module sit_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  sit_pkg::seg_pair_t in_seg,
  input  sit_pkg::limit_t   limit,
  output logic              out_valid,
  output sit_pkg::div_t     out_div
);
  import sit_pkg::*;

  // stage 1
  logic                     v1_r;
  logic signed [DIFF_W-1:0] a_r, b_r, c_r, d_r, e_r, f_r;
  logic signed [DIFF_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt, f_nxt;
  coord_t                   x0_1_r, y0_1_r;
  // stage 2
  logic                     v2_r;
  logic signed [PROD_W-1:0] p_ab_r, p_cd_r, p_eb_r, p_fd_r, p_ce_r, p_af_r;
  logic signed [PROD_W-1:0] p_ab_nxt, p_cd_nxt, p_eb_nxt, p_fd_nxt, p_ce_nxt, p_af_nxt;
  logic signed [DIFF_W-1:0] a2_r, c2_r;
  coord_t                   x0_2_r, y0_2_r;
  // stage 3
  logic                     v3_r;
  logic [SUM_W-1:0]         den3_r, nt3_r, nu3_r;
  logic [SUM_W-1:0]         den3_nxt, nt3_nxt, nu3_nxt;
  logic signed [DIFF_W-1:0] a3_r, c3_r;
  coord_t                   x0_3_r, y0_3_r;
  // stage 4
  logic                     v4_r;
  logic [SUM_W-1:0]         den4_r, nt4_r, nu4_r;
  logic [SUM_W-1:0]         den4_nxt, nt4_nxt, nu4_nxt;
  logic [COORD_WIDTH-1:0]   mag_x4_r, mag_y4_r, mag_x4_nxt, mag_y4_nxt;
  logic [DIFF_W-1:0]        abs_a, abs_c;
  logic                     neg_x4_r, neg_y4_r;
  coord_t                   x0_4_r, y0_4_r;
  // stage 5
  logic                     v5_r;
  div_t                     div5_r, div5_nxt;
  logic [NUM_W-1:0]         num_x, num_y;

  assign a_nxt = DIFF_W'(in_seg.a_start_x) - DIFF_W'(in_seg.a_end_x);
  assign b_nxt = DIFF_W'(in_seg.b_start_y) - DIFF_W'(in_seg.b_end_y);
  assign c_nxt = DIFF_W'(in_seg.a_start_y) - DIFF_W'(in_seg.a_end_y);
  assign d_nxt = DIFF_W'(in_seg.b_start_x) - DIFF_W'(in_seg.b_end_x);
  assign e_nxt = DIFF_W'(in_seg.a_start_x) - DIFF_W'(in_seg.b_start_x);
  assign f_nxt = DIFF_W'(in_seg.a_start_y) - DIFF_W'(in_seg.b_start_y);

  assign p_ab_nxt = PROD_W'(a_r) * PROD_W'(b_r);
  assign p_cd_nxt = PROD_W'(c_r) * PROD_W'(d_r);
  assign p_eb_nxt = PROD_W'(e_r) * PROD_W'(b_r);
  assign p_fd_nxt = PROD_W'(f_r) * PROD_W'(d_r);
  assign p_ce_nxt = PROD_W'(c_r) * PROD_W'(e_r);
  assign p_af_nxt = PROD_W'(a_r) * PROD_W'(f_r);

  assign den3_nxt = SUM_W'(p_ab_r) - SUM_W'(p_cd_r);
  assign nt3_nxt  = SUM_W'(p_eb_r) - SUM_W'(p_fd_r);
  assign nu3_nxt  = SUM_W'(p_ce_r) - SUM_W'(p_af_r);

  // give all three the sign of a non-negative denominator
  assign den4_nxt = den3_r[SUM_W-1] ? (SUM_W'(0) - den3_r) : den3_r;
  assign nt4_nxt  = den3_r[SUM_W-1] ? (SUM_W'(0) - nt3_r)  : nt3_r;
  assign nu4_nxt  = den3_r[SUM_W-1] ? (SUM_W'(0) - nu3_r)  : nu3_r;
  assign abs_a      = a3_r[DIFF_W-1] ? (DIFF_W'(0) - a3_r) : a3_r;
  assign abs_c      = c3_r[DIFF_W-1] ? (DIFF_W'(0) - c3_r) : c3_r;
  assign mag_x4_nxt = abs_a[COORD_WIDTH-1:0];
  assign mag_y4_nxt = abs_c[COORD_WIDTH-1:0];

  assign num_x = NUM_W'(nt4_r[MAG_W-1:0]) * NUM_W'(mag_x4_r);
  assign num_y = NUM_W'(nt4_r[MAG_W-1:0]) * NUM_W'(mag_y4_r);

  always_comb begin
    div5_nxt.hit   = (den4_r != '0) && (den4_r >= SUM_W'(limit))
                  && !nt4_r[SUM_W-1] && (nt4_r <= den4_r)
                  && !nu4_r[SUM_W-1] && (nu4_r <= den4_r);
    div5_nxt.neg_x = neg_x4_r;
    div5_nxt.neg_y = neg_y4_r;
    div5_nxt.x0    = x0_4_r;
    div5_nxt.y0    = y0_4_r;
    div5_nxt.den   = den4_r[MAG_W-1:0];
    div5_nxt.rem_x = num_x[NUM_W-1:COORD_WIDTH];
    div5_nxt.lo_x  = num_x[COORD_WIDTH-1:0];
    div5_nxt.rem_y = num_y[NUM_W-1:COORD_WIDTH];
    div5_nxt.lo_y  = num_y[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      c_r      <= c_nxt;
      d_r      <= d_nxt;
      e_r      <= e_nxt;
      f_r      <= f_nxt;
      x0_1_r   <= in_seg.a_start_x;
      y0_1_r   <= in_seg.a_start_y;

      p_ab_r   <= p_ab_nxt;
      p_cd_r   <= p_cd_nxt;
      p_eb_r   <= p_eb_nxt;
      p_fd_r   <= p_fd_nxt;
      p_ce_r   <= p_ce_nxt;
      p_af_r   <= p_af_nxt;
      a2_r     <= a_r;
      c2_r     <= c_r;
      x0_2_r   <= x0_1_r;
      y0_2_r   <= y0_1_r;

      den3_r   <= den3_nxt;
      nt3_r    <= nt3_nxt;
      nu3_r    <= nu3_nxt;
      a3_r     <= a2_r;
      c3_r     <= c2_r;
      x0_3_r   <= x0_2_r;
      y0_3_r   <= y0_2_r;

      den4_r   <= den4_nxt;
      nt4_r    <= nt4_nxt;
      nu4_r    <= nu4_nxt;
      mag_x4_r <= mag_x4_nxt;
      mag_y4_r <= mag_y4_nxt;
      neg_x4_r <= !a3_r[DIFF_W-1];  // dx = -a
      neg_y4_r <= !c3_r[DIFF_W-1];
      x0_4_r   <= x0_3_r;
      y0_4_r   <= y0_3_r;

      div5_r   <= div5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_div   = div5_r;

endmodule

// ----- hw/rtl/sit_div_step.sv -----
// ----------------------------------------------------------------------------
// sit_div_step
// One restoring-division step for both coordinate lanes; one quotient bit
// per lane per stage.
// ----------------------------------------------------------------------------
module sit_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  sit_pkg::div_t in_div,
  output logic          out_valid,
  output sit_pkg::div_t out_div
);
  import sit_pkg::*;

  logic             v_r;
  div_t             div_r, div_nxt;
  logic [MAG_W:0]   trial_x, trial_y, den_ext;
  logic             ge_x, ge_y;
  logic [MAG_W:0]   sub_x, sub_y;

  assign den_ext = {1'b0, in_div.den};
  assign trial_x = {in_div.rem_x, in_div.lo_x[COORD_WIDTH-1]};
  assign trial_y = {in_div.rem_y, in_div.lo_y[COORD_WIDTH-1]};
  assign ge_x    = trial_x >= den_ext;
  assign ge_y    = trial_y >= den_ext;
  assign sub_x   = trial_x - den_ext;
  assign sub_y   = trial_y - den_ext;

  always_comb begin
    div_nxt       = in_div;
    div_nxt.rem_x = ge_x ? sub_x[MAG_W-1:0] : trial_x[MAG_W-1:0];
    div_nxt.rem_y = ge_y ? sub_y[MAG_W-1:0] : trial_y[MAG_W-1:0];
    div_nxt.lo_x  = {in_div.lo_x[COORD_WIDTH-2:0], ge_x};
    div_nxt.lo_y  = {in_div.lo_y[COORD_WIDTH-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_div   = div_r;

endmodule

// ----- hw/rtl/sit_out.sv -----
// ----------------------------------------------------------------------------
// sit_out
// Crossing point assembly and output register with skid stage.
// ----------------------------------------------------------------------------
module sit_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  sit_pkg::div_t      in_div,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sit_pkg::res_t      out_res,
  output sit_pkg::out_stat_t stat
);
  import sit_pkg::*;

  logic   out_valid_r, skid_valid_r;
  res_t   out_res_r, skid_res_r;
  res_t   res_nxt;
  coord_t step_x, step_y;
  logic   push, pop;

  assign step_x = in_div.neg_x ? coord_t'(COORD_WIDTH'(0) - in_div.lo_x) : coord_t'(in_div.lo_x);
  assign step_y = in_div.neg_y ? coord_t'(COORD_WIDTH'(0) - in_div.lo_y) : coord_t'(in_div.lo_y);

  always_comb begin
    res_nxt.hit     = in_div.hit;
    res_nxt.cross_x = in_div.hit ? coord_t'(in_div.x0 + step_x) : '0;
    res_nxt.cross_y = in_div.hit ? coord_t'(in_div.y0 + step_y) : '0;
  end

  assign ready = !skid_valid_r;
  assign push  = in_valid && !skid_valid_r;
  assign pop   = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_res_r <= skid_valid_r ? skid_res_r : res_nxt;
    end else if (push) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res        = out_res_r;
  assign stat.skid_full = skid_valid_r;
  assign stat.out_busy  = out_valid_r;

endmodule

// ----- hw/rtl/segment_intersection_test.sv -----
// Pipeline: 5 front-end stages, 16 divider stages and 1 output register
// between an accepted request and out_tvalid.
// Throughput: one request per cycle while the skid stage is empty (in_tready
// high); every stage holds one request and the divider has one stage per quotient bit.
// Reset (rst_n low, synchronous): pipeline and skid emptied, parallel_limit = 1.
// ----------------------------------------------------------------------------
// segment_intersection_test
// Parametric segment crossing test with exact hit check and crossing point.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_defines.svh"

module segment_intersection_test (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  sit_pkg::limit_t                 cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [sit_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // cross_x, cross_y
  output logic [sit_pkg::OUT_DATA_W-1:0]  out_tdata,
  // hit
  output logic                            out_tuser
);
  import sit_pkg::*;

  limit_t     parallel_limit_r;
  seg_pair_t  in_seg;
  logic       en;
  logic       front_valid;
  div_t       front_div;
  logic [COORD_WIDTH:0] pipe_valid;
  div_t       pipe_div [0:COORD_WIDTH];
  res_t       res;
  out_stat_t  out_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parallel_limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      parallel_limit_r <= cfg_data;
    end
  end

  assign in_seg.a_start_x = in_tdata[0*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.a_start_y = in_tdata[1*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.a_end_x   = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.a_end_y   = in_tdata[3*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.b_start_x = in_tdata[4*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.b_start_y = in_tdata[5*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.b_end_x   = in_tdata[6*COORD_WIDTH +: COORD_WIDTH];
  assign in_seg.b_end_y   = in_tdata[7*COORD_WIDTH +: COORD_WIDTH];

  assign in_tready = en;

  sit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_seg    (in_seg),
    .limit     (parallel_limit_r),
    .out_valid (front_valid),
    .out_div   (front_div)
  );

  assign pipe_valid[0] = front_valid;
  assign pipe_div[0]   = front_div;

  for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_div
    sit_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (pipe_valid[i]),
      .in_div    (pipe_div[i]),
      .out_valid (pipe_valid[i+1]),
      .out_div   (pipe_div[i+1])
    );
  end

  sit_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pipe_valid[COORD_WIDTH]),
    .in_div    (pipe_div[COORD_WIDTH]),
    .ready     (en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .stat      (out_stat)
  );

  assign out_tdata = OUT_DATA_W'({res.cross_y, res.cross_x});
  assign out_tuser = res.hit;

  `SIT_ASSERT_IMP(a_nohit_zero, out_tvalid && !out_tuser, out_tdata == '0, "no hit, nonzero point")
  `SIT_ASSERT_IMP(a_skid_implies_busy, out_stat.skid_full,
                  out_stat.out_busy && !in_tready, "skid full while idle or open")
  `SIT_ASSERT_NXT(a_skid_holds, out_stat.skid_full && !out_tready,
                  out_stat.skid_full, "skid request dropped")

endmodule

// ----- tb/tb_segment_intersection_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_test
// Streams segment pairs through the crossing test at several parallel limits:
// directed corner cases, then crossing, near-parallel, touching, extreme-value and
// raw random pairs. Every result is checked against an in-bench predictor under
// random stalls on both sides (none in one phase) and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test;
  import sit_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 160;
  localparam int HOLD_AFTER     = 700;
  localparam int TAIL_CYCLES    = 40;

  typedef logic [IN_DATA_W-1:0] req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  limit_t                cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  req_t                  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // cross_x, cross_y
  logic [OUT_DATA_W-1:0] out_tdata;
  // hit
  logic                  out_tuser;

  req_t   pending_reqs [$];
  res_t   crossing_q   [$];
  limit_t cur_limit    = LIMIT_RESET;
  int     n_queued     = 0;
  int     n_done       = 0;
  int     n_accepted   = 0;
  int     n_fail       = 0;
  int     idle_cycles  = 0;
  int     hold_left    = 0;
  logic   held         = 1'b0;
  logic   no_gaps      = 1'b0;

  segment_intersection_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic res_t predict_crossing(req_t req, limit_t lim);
    longint pt [8];
    longint den, num_t, num_u, lim_v, dx, dy, qx, qy;
    coord_t c;
    res_t   r;
    for (int i = 0; i < 8; i++) begin
      c = req[i*COORD_WIDTH +: COORD_WIDTH];
      pt[i] = c;
    end
    lim_v = lim;
    den   = (pt[0] - pt[2]) * (pt[5] - pt[7]) - (pt[1] - pt[3]) * (pt[4] - pt[6]);
    num_t = (pt[0] - pt[4]) * (pt[5] - pt[7]) - (pt[1] - pt[5]) * (pt[4] - pt[6]);
    num_u = (pt[1] - pt[3]) * (pt[0] - pt[4]) - (pt[0] - pt[2]) * (pt[1] - pt[5]);
    if (den < 0) begin
      den   = -den;
      num_t = -num_t;
      num_u = -num_u;
    end
    r = '0;
    r.hit = den != 0 && den >= lim_v && num_t >= 0 && num_t <= den
            && num_u >= 0 && num_u <= den;
    if (r.hit) begin
      dx = pt[2] - pt[0];
      dy = pt[3] - pt[1];
      qx = num_t * (dx < 0 ? -dx : dx) / den;
      qy = num_t * (dy < 0 ? -dy : dy) / den;
      r.cross_x = coord_t'(pt[0] + (dx < 0 ? -qx : qx));
      r.cross_y = coord_t'(pt[1] + (dy < 0 ? -qy : qy));
    end
    return r;
  endfunction

  function automatic int span_rand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return span_rand(-32768, 32767);
    endcase
  endfunction

  task automatic add_req(int ax0, int ay0, int ax1, int ay1,
                         int bx0, int by0, int bx1, int by1);
    pending_reqs.push_back({coord_t'(by1), coord_t'(bx1), coord_t'(by0), coord_t'(bx0),
                            coord_t'(ay1), coord_t'(ax1), coord_t'(ay0), coord_t'(ax0)});
    n_queued++;
  endtask

  task automatic add_random(int count);
    int mode, r, cx, cy, vx, vy, wx, wy, px, py, dx, dy, qx, qy, k, m;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(99);
      if (mode < 45) begin
        // pair built around a common point, so most of these cross
        case ($urandom_range(2))
          0: r = 16;
          1: r = 512;
          default: r = 16000;
        endcase
        cx = span_rand(-16000, 16000);
        cy = span_rand(-16000, 16000);
        vx = span_rand(-r, r);
        vy = span_rand(-r, r);
        wx = span_rand(-r, r);
        wy = span_rand(-r, r);
        add_req(cx + vx, cy + vy, cx - vx + span_rand(-4, 4), cy - vy + span_rand(-4, 4),
                cx + wx, cy + wy, cx - wx + span_rand(-4, 4), cy - wy + span_rand(-4, 4));
      end else if (mode < 60) begin
        // nearly parallel, short segments: denominator near the limit
        px = span_rand(-30000, 30000);
        py = span_rand(-30000, 30000);
        dx = span_rand(-16, 16);
        dy = span_rand(-16, 16);
        qx = px + span_rand(-8, 8);
        qy = py + span_rand(-8, 8);
        add_req(px, py, px + dx, py + dy,
                qx, qy, qx + dx + span_rand(-2, 2), qy + dy + span_rand(-2, 2));
      end else if (mode < 70) begin
        // one endpoint of B on A: at A's ends or at A's midpoint
        px = span_rand(-20000, 20000);
        py = span_rand(-20000, 20000);
        k  = span_rand(-4000, 4000);
        m  = span_rand(-4000, 4000);
        case ($urandom_range(2))
          0: begin qx = px; qy = py; end
          1: begin qx = px + 2 * k; qy = py + 2 * m; end
          default: begin qx = px + k; qy = py + m; end
        endcase
        wx = qx + span_rand(-8000, 8000);
        wy = qy + span_rand(-8000, 8000);
        if ($urandom_range(1))
          add_req(px, py, px + 2 * k, py + 2 * m, qx, qy, wx, wy);
        else
          add_req(px, py, px + 2 * k, py + 2 * m, wx, wy, qx, qy);
      end else if (mode < 80) begin
        add_req(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end else begin
        pending_reqs.push_back({$urandom, $urandom, $urandom, $urandom});
        n_queued++;
      end
    end
  endtask

  task automatic wait_drained();
    while (n_done != n_queued) @(posedge clk);
  endtask

  task automatic write_limit(limit_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 20)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_reqs.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      held       <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!held && n_accepted >= HOLD_AFTER) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      held       <= 1'b1;
    end else begin
      out_tready <= no_gaps || $urandom_range(99) >= 20;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_done <= n_done + 1;
      if (crossing_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, out_tuser,
                 $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
        n_fail++;
      end else begin
        want = crossing_q.pop_front();
        if (want.hit !== out_tuser || want.cross_x !== out_tdata[15:0]
            || want.cross_y !== out_tdata[31:16]) begin
          $display("%0t: mismatch expected hit=%0b x=%0d y=%0d actual hit=%0b x=%0d y=%0d",
                   $time, want.hit, want.cross_x, want.cross_y, out_tuser,
                   $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
          n_fail++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      crossing_q.push_back(predict_crossing(in_tdata, cur_limit));
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && cfg_valid && cfg_ready)
      cur_limit <= cfg_data;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("tb_segment_intersection_test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: simple cross, extremes, touching ends, parallel and misses
    add_req(0, 0, 160, 160, 0, 160, 160, 0);
    add_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_req(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_req(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
    add_req(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    add_req(0, 0, 100, 0, 0, -50, 0, 50);
    add_req(0, 0, 100, 0, 100, -50, 100, 50);
    add_req(0, 0, 100, 0, 50, 0, 50, 80);
    add_req(0, 0, 100, 0, 50, 80, 50, 0);
    add_req(0, 0, 100, 0, 50, 0, 150, 0);
    add_req(0, 0, 100, 100, 0, 10, 100, 110);
    add_req(5, 5, 5, 5, 0, 0, 10, 10);
    add_req(0, 0, 10, 0, 50, -10, 50, 10);
    add_req(0, 0, 100, 0, 50, 10, 50, 20);
    add_req(0, 0, 100, 0, -50, -10, -50, 10);
    add_req(3, 0, -4, 7, -4, 0, 3, 5);
    add_req(0, 0, -7, -3, -1, -3, -5, 1);
    add_req(0, 0, 16, 0, 8, -1, 9, 1);
    add_req(0, 0, 1, 0, 0, 0, 1, 1);
    add_req(0, 0, 0, 0, 0, 0, 0, 0);
    add_random(400);
    wait_drained();

    write_limit(limit_t'(0));
    add_random(400);
    wait_drained();

    write_limit(limit_t'(255));
    add_random(400);
    wait_drained();

    write_limit(limit_t'($urandom_range(2, 254)));
    no_gaps = 1'b1;
    add_random(400);
    wait_drained();
    no_gaps = 1'b0;

    write_limit(LIMIT_RESET);
    add_random(350);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0 && crossing_q.size() == 0) begin
      $display("tb_segment_intersection_test passed");
    end else begin
      $display("tb_segment_intersection_test failed");
    end
    $finish;
  end

endmodule
